[hdl/efc_pkg.sv]
// ----------------------------------------------------------------------------
// efc_pkg: shared types and constants of the EFI to multiboot map converter
// Beat structs, class codes, hole bounds and the UEFI type classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package efc_pkg;

  // Map capacity and page size
  localparam int unsigned MAX_ENTRIES = 128;
  localparam int unsigned PAGE_SHIFT  = 12;

  // Legacy hole between 640 KiB and 1 MiB
  localparam logic [63:0] HOLE_LO = 64'h0000_0000_000A_0000;
  localparam logic [63:0] HOLE_HI = 64'h0000_0000_0010_0000;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  // UEFI type codes that are not reserved
  localparam logic [4:0] EFI_LDR_CODE     = 5'd1;
  localparam logic [4:0] EFI_LDR_DATA     = 5'd2;
  localparam logic [4:0] EFI_BS_CODE      = 5'd3;
  localparam logic [4:0] EFI_BS_DATA      = 5'd4;
  localparam logic [4:0] EFI_CONVENTIONAL = 5'd7;
  localparam logic [4:0] EFI_ACPI_RECLAIM = 5'd9;
  localparam logic [4:0] EFI_ACPI_NVS     = 5'd10;

  // Multiboot region classes
  typedef enum logic [2:0] {
    CLS_AVAIL = 3'd1,
    CLS_RSVD  = 3'd2,
    CLS_RECL  = 3'd3,
    CLS_NVS   = 3'd4
  } cls_e;

  // Input beat
  typedef struct packed {
    logic [4:0]  efi_type;
    logic [63:0] base_addr;
    logic [51:0] page_count;
    logic        map_end;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic [63:0] entry_base;
    logic [63:0] entry_len;
    logic [2:0]  entry_type;
    logic [7:0]  entry_index;
    logic        overflow;
    logic        run_last;
  } out_item_t;

  // Classified descriptor: low part below the hole, main part, flush request
  typedef struct packed {
    logic        has_lo;
    logic [63:0] lo_base;
    logic [63:0] lo_len;
    logic        has_main;
    logic [63:0] main_base;
    logic [63:0] main_len;
    cls_e        main_cls;
    logic        flush;
  } qent_t;

  // UEFI type to multiboot class
  function automatic cls_e map_class(input logic [4:0] t);
    cls_e c;
    case (t)
      EFI_LDR_CODE, EFI_LDR_DATA, EFI_BS_CODE, EFI_BS_DATA,
      EFI_CONVENTIONAL: c = CLS_AVAIL;
      EFI_ACPI_RECLAIM: c = CLS_RECL;
      EFI_ACPI_NVS:     c = CLS_NVS;
      default:          c = CLS_RSVD;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/efc_front.sv]
// ----------------------------------------------------------------------------
// efc_front: descriptor classifier
// Maps the UEFI type, sizes the region and cuts usable memory at the hole.
// ----------------------------------------------------------------------------
`default_nettype none

module efc_front (
  input  wire              in_valid_i,
  input  efc_pkg::in_item_t in_item_i,
  input  wire              q_full_i,
  output logic             in_stall_o,
  output logic             q_push_o,
  output efc_pkg::qent_t   q_ent_o
);

  efc_pkg::cls_e cls;
  logic [63:0]   start;
  logic [63:0]   size;
  logic [63:0]   fin;
  logic          cut;

  // Classify and split
  always_comb begin
    cls   = efc_pkg::map_class(in_item_i.efi_type);
    start = in_item_i.base_addr;
    size  = 64'(in_item_i.page_count) << efc_pkg::PAGE_SHIFT;
    fin   = start + size;
    cut   = (cls == efc_pkg::CLS_AVAIL) && (start < efc_pkg::HOLE_HI) &&
            (fin > efc_pkg::HOLE_LO);

    q_ent_o.has_lo    = cut && (start < efc_pkg::HOLE_LO);
    q_ent_o.lo_base   = start;
    q_ent_o.lo_len    = efc_pkg::HOLE_LO - start;
    q_ent_o.has_main  = !(cut && (fin <= efc_pkg::HOLE_HI));
    q_ent_o.main_base = cut ? efc_pkg::HOLE_HI : start;
    q_ent_o.main_len  = cut ? (fin - efc_pkg::HOLE_HI) : size;
    q_ent_o.main_cls  = cls;
    q_ent_o.flush     = in_item_i.map_end;
  end

  // Handshake into the queue
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

[hdl/efc_fifo.sv]
// ----------------------------------------------------------------------------
// efc_fifo: short queue between classifier and merge engine
// Holds classified descriptors so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module efc_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  efc_pkg::qent_t  push_ent_i,
  input  wire             pop_i,
  output logic            full_o,
  output logic            empty_o,
  output efc_pkg::qent_t  head_o
);

  localparam int unsigned PTR_W = (efc_pkg::QDEPTH > 1) ? $clog2(efc_pkg::QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(efc_pkg::QDEPTH + 1);

  efc_pkg::qent_t     mem_q [efc_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(efc_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(efc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(efc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_ent_i;
    end
  end

endmodule

`default_nettype wire

[hdl/efc_back.sv]
// ----------------------------------------------------------------------------
// efc_back: merge engine and output register
// Walks the descriptor parts one per cycle unless stalled, merging into the
// pending entry and emitting map entries with index and overflow tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module efc_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_empty_i,
  input  efc_pkg::qent_t     q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output efc_pkg::out_item_t out_item_o
);

  // Part mask bits: low region, main region, flush
  localparam int unsigned P_LO    = 0;
  localparam int unsigned P_MAIN  = 1;
  localparam int unsigned P_FLUSH = 2;

  logic               busy_q, busy_d;
  logic [2:0]         rem_q, rem_d;
  logic [2:0]         cur, sel;
  logic               last, adv;

  logic               pend_v_q, pend_v_d;
  logic [63:0]        pend_base_q, pend_base_d;
  logic [63:0]        pend_len_q, pend_len_d;
  logic [63:0]        pend_end_q, pend_end_d;
  efc_pkg::cls_e      pend_cls_q, pend_cls_d;
  logic [7:0]         cnt_q, cnt_d;
  logic               ovf_q, ovf_d;

  logic               out_v_q, out_v_d;
  efc_pkg::out_item_t out_q, out_d;

  logic               is_reg, emit, merge, full_map;
  logic [63:0]        r_base, r_len;
  efc_pkg::cls_e      r_cls;

  // Part selection and sequencing
  always_comb begin
    cur = busy_q ? rem_q :
          {q_head_i.flush, q_head_i.has_main, q_head_i.has_lo};
    if (cur[P_LO])        sel = 3'b001;
    else if (cur[P_MAIN]) sel = 3'b010;
    else if (cur[P_FLUSH]) sel = 3'b100;
    else                  sel = 3'b000;
    last = ((cur & ~sel) == 3'b000);
    adv  = !q_empty_i && (!out_v_q || !out_stall_i);

    q_pop_o = adv && last;
    busy_d  = busy_q;
    rem_d   = rem_q;
    if (adv) begin
      busy_d = !last;
      rem_d  = cur & ~sel;
    end
  end

  // Merge, emit and pending update
  always_comb begin
    is_reg = sel[P_LO] || sel[P_MAIN];
    r_base = sel[P_LO] ? q_head_i.lo_base : q_head_i.main_base;
    r_len  = sel[P_LO] ? q_head_i.lo_len  : q_head_i.main_len;
    r_cls  = sel[P_LO] ? efc_pkg::CLS_AVAIL : q_head_i.main_cls;
    merge  = pend_v_q && (pend_cls_q == r_cls) && (pend_end_q == r_base);
    emit   = adv && pend_v_q && ((is_reg && !merge) || sel[P_FLUSH]);
    full_map = (cnt_q >= 8'(efc_pkg::MAX_ENTRIES));

    pend_v_d    = pend_v_q;
    pend_base_d = pend_base_q;
    pend_len_d  = pend_len_q;
    pend_end_d  = pend_end_q;
    pend_cls_d  = pend_cls_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;

    if (adv && is_reg) begin
      if (merge) begin
        pend_len_d = pend_len_q + r_len;
        pend_end_d = pend_end_q + r_len;
      end else begin
        pend_v_d    = 1'b1;
        pend_base_d = r_base;
        pend_len_d  = r_len;
        pend_end_d  = r_base + r_len;
        pend_cls_d  = r_cls;
      end
    end else if (adv && sel[P_FLUSH]) begin
      pend_v_d = 1'b0;
    end

    if (emit) begin
      if (full_map) ovf_d = 1'b1;
      else          cnt_d = cnt_q + 1'b1;
    end

    // Output register
    out_d                  = out_q;
    out_d.entry_base       = pend_base_q;
    out_d.entry_len        = pend_len_q;
    out_d.entry_type       = pend_cls_q;
    out_d.entry_index      = full_map ? 8'(efc_pkg::MAX_ENTRIES) : cnt_q;
    out_d.overflow         = ovf_q || full_map;
    out_d.run_last         = last;
    if (!emit) out_d = out_q;

    if (emit)              out_v_d = 1'b1;
    else if (!out_stall_i) out_v_d = 1'b0;
    else                   out_v_d = out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rem_q    <= '0;
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      rem_q    <= rem_d;
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_base_q <= pend_base_d;
    pend_len_q  <= pend_len_d;
    pend_end_q  <= pend_end_d;
    pend_cls_q  <= pend_cls_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[hdl/efi_to_multiboot_memmap_converter.sv]
// An entry leaves from the output register in the cycle after the merge engine
// takes the part that closes it. Throughput: one descriptor part (low region,
// main region, flush) per cycle while the output is not stalled; the two-deep
// queue keeps the input open.
// Reset (rst_ni low, asynchronous) empties the queue, drops the pending entry
// and clears the entry count and the overflow flag.
// ----------------------------------------------------------------------------
// efi_to_multiboot_memmap_converter: UEFI descriptors to multiboot map
// Classifier front end, descriptor queue, merge engine with output register.
// ----------------------------------------------------------------------------
`default_nettype none

module efi_to_multiboot_memmap_converter (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  efc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output efc_pkg::out_item_t out_item_o
);

  logic           q_push, q_pop, q_full, q_empty;
  efc_pkg::qent_t q_in, q_head;

  efc_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .q_push_o   (q_push),
    .q_ent_o    (q_in)
  );

  efc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_ent_i (q_in),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  efc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Emitted class is always one of the four multiboot classes
  a_type_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.entry_type == 3'(efc_pkg::CLS_AVAIL) ||
                     out_item_o.entry_type == 3'(efc_pkg::CLS_RSVD)  ||
                     out_item_o.entry_type == 3'(efc_pkg::CLS_RECL)  ||
                     out_item_o.entry_type == 3'(efc_pkg::CLS_NVS)))
    else $error("entry_type out of range");

  // Index saturates at capacity
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.entry_index <= 8'(efc_pkg::MAX_ENTRIES)))
    else $error("entry_index beyond capacity");

  // No overflow while the map still has room
  a_ovf_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.entry_index < 8'(efc_pkg::MAX_ENTRIES)))
      |-> !out_item_o.overflow)
    else $error("overflow flagged below capacity");

endmodule

`default_nettype wire
